### rtl/vpt_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the vertex pivot transform.
`timescale 1ns / 1ps
package vpt_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned ANGLE_W = 26;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned TRIG_W = 32;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic signed [33:0] ONE_Q30 = 34'sh040000000;
  localparam logic signed [26:0] DEG_90 = 27'sd5898240;
  localparam logic signed [26:0] DEG_180 = 27'sd11796480;
  localparam logic signed [26:0] DEG_360 = 27'sd23592960;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [34:0] DEG2RAD_Q40 = 35'((PI_Q60 / 64'd180) >> 20);

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_PARAM_X = 3'd0,
    IDX_PARAM_Y = 3'd1,
    IDX_PARAM_Z = 3'd2,
    IDX_PIVOT_X = 3'd3,
    IDX_PIVOT_Y = 3'd4,
    IDX_PIVOT_Z = 3'd5,
    IDX_ANGLE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRANSLATE = 3'd0,
    MODE_SCALE     = 3'd1,
    MODE_ROT_X     = 3'd2,
    MODE_ROT_Y     = 3'd3,
    MODE_ROT_Z     = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_WRAP,
    CS_FOLD,
    CS_CONV,
    CS_LOAD,
    CS_ITER,
    CS_DONE
  } cordic_state_e;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [64:0] d1;
    logic signed [31:0] k2;
    logic signed [64:0] d2;
    logic signed [64:0] base;
    logic               scl;
    logic               pass;
    logic        [31:0] pv;
  } lane_op_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
    logic signed [31:0] r;
    begin
      case (idx)
        5'd0:  r = 32'sh3243F6A8;
        5'd1:  r = 32'sh1DAC6705;
        5'd2:  r = 32'sh0FADBAFC;
        5'd3:  r = 32'sh07F56EA6;
        5'd4:  r = 32'sh03FEAB76;
        5'd5:  r = 32'sh01FFD55B;
        5'd6:  r = 32'sh00FFFAAA;
        5'd7:  r = 32'sh007FFF55;
        5'd8:  r = 32'sh003FFFEA;
        5'd9:  r = 32'sh001FFFFD;
        5'd10: r = 32'sh000FFFFF;
        5'd11: r = 32'sh0007FFFF;
        5'd12: r = 32'sh0003FFFF;
        5'd13: r = 32'sh0001FFFF;
        5'd14: r = 32'sh0000FFFF;
        5'd15: r = 32'sh00007FFF;
        5'd16: r = 32'sh00003FFF;
        5'd17: r = 32'sh00001FFF;
        5'd18: r = 32'sh00000FFF;
        5'd19: r = 32'sh000007FF;
        5'd20: r = 32'sh000003FF;
        5'd21: r = 32'sh000001FF;
        5'd22: r = 32'sh000000FF;
        5'd23: r = 32'sh0000007F;
        5'd24: r = 32'sh0000003F;
        5'd25: r = 32'sh0000001F;
        5'd26: r = 32'sh0000000F;
        5'd27: r = 32'sh00000008;
        5'd28: r = 32'sh00000004;
        5'd29: r = 32'sh00000002;
        5'd30: r = 32'sh00000001;
        default: r = 32'sh00000000;
      endcase
      return r;
    end
  endfunction

endpackage

### rtl/vpt_cordic.sv
// Sequential sine and cosine unit for the configured rotation angle.
`timescale 1ns / 1ps
module vpt_cordic #(
  parameter int unsigned CORDIC_STEPS = vpt_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [vpt_pkg::ANGLE_W-1:0]    angle_i,
  output logic                                  busy_o,
  output logic signed [vpt_pkg::TRIG_W-1:0]     cos_o,
  output logic signed [vpt_pkg::TRIG_W-1:0]     sin_o
);

  localparam int unsigned CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  vpt_pkg::cordic_state_e state_q, state_d;
  logic signed [26:0] a_q, a_d;
  logic               flip_q, flip_d;
  logic               neg_q, neg_d;
  logic [57:0]        prod_q, prod_d;
  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [32:0] z_q, z_d;
  logic [CW-1:0]      i_q, i_d;
  logic signed [31:0] cos_q, cos_d, sin_q, sin_d;
  logic [22:0]        mag;
  logic [31:0]        rad;
  logic signed [33:0] xf, yf;
  logic signed [32:0] at;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vpt_pkg::CS_WRAP;
      i_q     <= '0;
      cos_q   <= '0;
      sin_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      cos_q   <= cos_d;
      sin_q   <= sin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    flip_q <= flip_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    flip_d  = flip_q;
    neg_d   = neg_q;
    prod_d  = prod_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    i_d     = i_q;
    cos_d   = cos_q;
    sin_d   = sin_q;
    mag     = a_q[26] ? 23'(-a_q) : a_q[22:0];
    rad     = 32'((prod_q + 58'd33554432) >> 26);
    at      = 33'(vpt_pkg::atan_q30(5'(i_q)));
    xf      = flip_q ? -x_q : x_q;
    yf      = flip_q ? -y_q : y_q;
    unique case (state_q)
      vpt_pkg::CS_IDLE: begin
        if (start_i) state_d = vpt_pkg::CS_WRAP;
      end
      vpt_pkg::CS_WRAP: begin
        a_d = {angle_i[25], angle_i};
        if (a_d > vpt_pkg::DEG_180) a_d = a_d - vpt_pkg::DEG_360;
        else if (a_d < -vpt_pkg::DEG_180) a_d = a_d + vpt_pkg::DEG_360;
        state_d = vpt_pkg::CS_FOLD;
      end
      vpt_pkg::CS_FOLD: begin
        flip_d = 1'b0;
        if (a_q > vpt_pkg::DEG_90) begin
          a_d    = a_q - vpt_pkg::DEG_180;
          flip_d = 1'b1;
        end else if (a_q < -vpt_pkg::DEG_90) begin
          a_d    = a_q + vpt_pkg::DEG_180;
          flip_d = 1'b1;
        end
        state_d = vpt_pkg::CS_CONV;
      end
      vpt_pkg::CS_CONV: begin
        prod_d  = 58'(mag) * 58'(vpt_pkg::DEG2RAD_Q40);
        neg_d   = a_q[26];
        state_d = vpt_pkg::CS_LOAD;
      end
      vpt_pkg::CS_LOAD: begin
        z_d     = neg_q ? -$signed({1'b0, rad}) : $signed({1'b0, rad});
        x_d     = vpt_pkg::CORDIC_GAIN;
        y_d     = '0;
        i_d     = '0;
        state_d = vpt_pkg::CS_ITER;
      end
      vpt_pkg::CS_ITER: begin
        if (!z_q[32]) begin
          x_d = x_q - (y_q >>> i_q);
          y_d = y_q + (x_q >>> i_q);
          z_d = z_q - at;
        end else begin
          x_d = x_q + (y_q >>> i_q);
          y_d = y_q - (x_q >>> i_q);
          z_d = z_q + at;
        end
        i_d = i_q + 1'b1;
        if (i_q == CW'(CORDIC_STEPS - 1)) state_d = vpt_pkg::CS_DONE;
      end
      vpt_pkg::CS_DONE: begin
        if (xf > vpt_pkg::ONE_Q30) cos_d = 32'(vpt_pkg::ONE_Q30);
        else if (xf < -vpt_pkg::ONE_Q30) cos_d = 32'(-vpt_pkg::ONE_Q30);
        else cos_d = 32'(xf);
        if (yf > vpt_pkg::ONE_Q30) sin_d = 32'(vpt_pkg::ONE_Q30);
        else if (yf < -vpt_pkg::ONE_Q30) sin_d = 32'(-vpt_pkg::ONE_Q30);
        else sin_d = 32'(yf);
        state_d = vpt_pkg::CS_IDLE;
      end
      default: state_d = vpt_pkg::CS_IDLE;
    endcase
    if (start_i) state_d = vpt_pkg::CS_WRAP;
  end

  assign busy_o = (state_q != vpt_pkg::CS_IDLE);
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

### rtl/vpt_lane.sv
// One coordinate lane: partial products, sum, rounding and saturation.
`timescale 1ns / 1ps
module vpt_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  vpt_pkg::lane_op_t  op_i,
  output logic [31:0]        val_o,
  output logic               sat_o
);

  localparam logic [111:0] HALF = 112'd1 << 45;

  logic signed [64:0] p1h_q, p1l_q, p2h_q, p2l_q;
  logic signed [64:0] base3_q, base4_q;
  logic               scl3_q, scl4_q, pass3_q, pass4_q, pass5_q;
  logic [31:0]        pv3_q, pv4_q, pv5_q;
  logic signed [97:0] tsum_d, tsum_q;
  logic [111:0]       acc_d, acc_q;
  logic [111:0]       sh, bs;
  logic [34:0]        top;
  logic [31:0]        val_d, val_q;
  logic               sat_d, sat_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1h_q   <= op_i.k1 * $signed(op_i.d1[64:32]);
      p1l_q   <= op_i.k1 * $signed({1'b0, op_i.d1[31:0]});
      p2h_q   <= op_i.k2 * $signed(op_i.d2[64:32]);
      p2l_q   <= op_i.k2 * $signed({1'b0, op_i.d2[31:0]});
      base3_q <= op_i.base;
      scl3_q  <= op_i.scl;
      pass3_q <= op_i.pass;
      pv3_q   <= op_i.pv;
      tsum_q  <= tsum_d;
      base4_q <= base3_q;
      scl4_q  <= scl3_q;
      pass4_q <= pass3_q;
      pv4_q   <= pv3_q;
      acc_q   <= acc_d;
      pass5_q <= pass4_q;
      pv5_q   <= pv4_q;
      val_q   <= val_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (en_i) begin
      sat_q <= sat_d;
    end
  end

  always_comb begin
    tsum_d = $signed({p1h_q[64], p1h_q, 32'd0})
           + $signed({{33{p1l_q[64]}}, p1l_q})
           + $signed({p2h_q[64], p2h_q, 32'd0})
           + $signed({{33{p2l_q[64]}}, p2l_q});
    sh     = scl4_q ? {tsum_q, 14'd0} : {{14{tsum_q[97]}}, tsum_q};
    bs     = {{17{base4_q[64]}}, base4_q, 30'd0};
    acc_d  = sh + bs + HALF;
    top    = acc_q[111:77];
    if (pass5_q) begin
      val_d = pv5_q;
      sat_d = 1'b0;
    end else if ((&top) || !(|top)) begin
      val_d = acc_q[77:46];
      sat_d = 1'b0;
    end else begin
      val_d = acc_q[111] ? 32'h80000000 : 32'h7FFFFFFF;
      sat_d = 1'b1;
    end
  end

  assign val_o = val_q;
  assign sat_o = sat_q;

endmodule

### rtl/vertex_pivot_transform.sv
// Top level of the vertex pivot transform: config registers, front stages and lanes.
// Front stage registers feed lane product, sum, accumulator and output registers.
// Throughput: one vertex per cycle while the sequencer is idle; the pipeline advances
// whenever the output is free. An angle write runs the sine/cosine sequencer, with
// s_axis_tready low in the write cycle and meanwhile; reset starts that run for zero.
// Reset clears all config registers and the stage valid bits.
`timescale 1ns / 1ps
module vertex_pivot_transform #(
  parameter int unsigned CORDIC_STEPS = vpt_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // x_in, y_in, z_in, w_in
  input  logic [2:0]   s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // x_out, y_out, z_out, w_out
  output logic [0:0]   m_axis_tuser,  // saturated
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned NSTG = 6;

  logic signed [31:0] param_q [3];
  logic signed [31:0] pivot_q [3];
  logic signed [25:0] angle_q;
  logic               start;
  logic               busy;
  logic signed [31:0] cos_v, sin_v;
  logic               adv;
  logic               take;
  logic [NSTG-1:0]    vld_q;
  logic [31:0]        w_q [NSTG];
  logic [2:0]         mode1_q, mode2_q;
  logic signed [31:0] c1_q [3];
  logic signed [63:0] ph1_q [3];
  logic signed [63:0] th1_q [3];
  logic signed [64:0] d2_q [3];
  logic signed [64:0] ts2_q [3];
  logic signed [64:0] ph2_q [3];
  logic [31:0]        c2_q [3];
  vpt_pkg::lane_op_t  op [3];
  logic [31:0]        val [3];
  logic [2:0]         sat;

  assign start = cfg_we_i && (cfg_idx_i == vpt_pkg::IDX_ANGLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      param_q <= '{default: '0};
      pivot_q <= '{default: '0};
      angle_q <= '0;
    end else if (cfg_we_i) begin
      unique case (vpt_pkg::cfg_idx_e'(cfg_idx_i))
        vpt_pkg::IDX_PARAM_X: param_q[0] <= cfg_data_i;
        vpt_pkg::IDX_PARAM_Y: param_q[1] <= cfg_data_i;
        vpt_pkg::IDX_PARAM_Z: param_q[2] <= cfg_data_i;
        vpt_pkg::IDX_PIVOT_X: pivot_q[0] <= cfg_data_i;
        vpt_pkg::IDX_PIVOT_Y: pivot_q[1] <= cfg_data_i;
        vpt_pkg::IDX_PIVOT_Z: pivot_q[2] <= cfg_data_i;
        vpt_pkg::IDX_ANGLE:   angle_q    <= cfg_data_i[25:0];
        default: ;
      endcase
    end
  end

  vpt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .angle_i (angle_q),
    .busy_o  (busy),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  assign adv           = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = adv && !busy && !start;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q[0]  <= s_axis_tdata[127:96];
      for (int s = 1; s < NSTG; s++) w_q[s] <= w_q[s-1];
      mode1_q <= s_axis_tuser;
      mode2_q <= mode1_q;
      for (int j = 0; j < 3; j++) begin
        c1_q[j]  <= s_axis_tdata[32*j +: 32];
        ph1_q[j] <= pivot_q[j] * $signed(s_axis_tdata[127:96]);
        th1_q[j] <= param_q[j] * $signed(s_axis_tdata[127:96]);
        d2_q[j]  <= $signed({{17{c1_q[j][31]}}, c1_q[j], 16'd0})
                  - $signed({ph1_q[j][63], ph1_q[j]});
        ts2_q[j] <= $signed({{17{c1_q[j][31]}}, c1_q[j], 16'd0})
                  + $signed({th1_q[j][63], th1_q[j]});
        ph2_q[j] <= $signed({ph1_q[j][63], ph1_q[j]});
        c2_q[j]  <= c1_q[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      op[j].k1   = '0;
      op[j].d1   = '0;
      op[j].k2   = '0;
      op[j].d2   = '0;
      op[j].base = ph2_q[j];
      op[j].scl  = 1'b0;
      op[j].pass = 1'b1;
      op[j].pv   = c2_q[j];
    end
    unique case (mode2_q)
      vpt_pkg::MODE_TRANSLATE: begin
        for (int j = 0; j < 3; j++) begin
          op[j].base = ts2_q[j];
          op[j].pass = 1'b0;
        end
      end
      vpt_pkg::MODE_SCALE: begin
        for (int j = 0; j < 3; j++) begin
          op[j].k1   = param_q[j];
          op[j].d1   = d2_q[j];
          op[j].scl  = 1'b1;
          op[j].pass = 1'b0;
        end
      end
      vpt_pkg::MODE_ROT_X: begin
        op[1].k1 = cos_v;  op[1].d1 = d2_q[1]; op[1].k2 = -sin_v; op[1].d2 = d2_q[2];
        op[2].k1 = sin_v;  op[2].d1 = d2_q[1]; op[2].k2 = cos_v;  op[2].d2 = d2_q[2];
        op[1].pass = 1'b0;
        op[2].pass = 1'b0;
      end
      vpt_pkg::MODE_ROT_Y: begin
        op[0].k1 = cos_v;  op[0].d1 = d2_q[0]; op[0].k2 = sin_v;  op[0].d2 = d2_q[2];
        op[2].k1 = -sin_v; op[2].d1 = d2_q[0]; op[2].k2 = cos_v;  op[2].d2 = d2_q[2];
        op[0].pass = 1'b0;
        op[2].pass = 1'b0;
      end
      vpt_pkg::MODE_ROT_Z: begin
        op[0].k1 = cos_v;  op[0].d1 = d2_q[0]; op[0].k2 = -sin_v; op[0].d2 = d2_q[1];
        op[1].k1 = sin_v;  op[1].d1 = d2_q[0]; op[1].k2 = cos_v;  op[1].d2 = d2_q[1];
        op[0].pass = 1'b0;
        op[1].pass = 1'b0;
      end
      default: ;
    endcase
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    vpt_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .op_i   (op[j]),
      .val_o  (val[j]),
      .sat_o  (sat[j])
    );
  end

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = {w_q[NSTG-1], val[2], val[1], val[0]};
  assign m_axis_tuser  = |sat;

endmodule

### rtl/vpt_checker.sv
// Port-level checker for the vertex pivot transform, bound to the top level.
`timescale 1ns / 1ps
module vpt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         cfg_we_i,
  input logic [2:0]   cfg_idx_i
);

  localparam logic [2:0] IDX_ANGLE = vpt_pkg::IDX_ANGLE;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_angle_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == IDX_ANGLE |-> !s_axis_tready)
    else $error("request taken during angle write");

  a_angle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == IDX_ANGLE |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("request taken while sine and cosine settle");

endmodule

bind vertex_pivot_transform vpt_checker u_vpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i)
);

### tb/sv/tb_top.sv
// Testbench for vertex_pivot_transform: directed and random vertices checked against a predictor.
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        sat;
  } vertex_res_t;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    bit          typed;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] ez;
  } vertex_row_t;

  localparam longint Q16_DEG = 65536;
  localparam longint unsigned RAD_PER_DEG_Q40 = (64'h3243F6A8885A308D / 64'd180) >> 20;
  localparam longint GAIN_Q30 = 64'h26DD3B6A;
  localparam longint UNIT_Q30 = 64'h40000000;
  localparam int TRIG_STEPS = 24;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // x_in, y_in, z_in, w_in
  logic [2:0]   s_axis_tuser = '0;  // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;       // x_out, y_out, z_out, w_out
  logic [0:0]   m_axis_tuser;       // saturated
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;

  longint      scale_par [3];
  longint      pivot_pt [3];
  longint      angle_q16;
  longint      atan_q30 [TRIG_STEPS];
  vertex_res_t expected_vertices [$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  vertex_pivot_transform u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic signed [127:0] wide_mul(longint a, longint b);
    logic signed [127:0] pa;
    logic signed [127:0] pb;
    pa = a;
    pb = b;
    return pa * pb;
  endfunction

  function automatic logic [31:0] round_clip(logic signed [127:0] acc, int frac, inout bit sat);
    logic signed [127:0] q;
    q = (acc + (128'sd1 <<< (frac - 1))) >>> frac;
    if (q > 128'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (q < -128'sh80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return q[31:0];
  endfunction

  function automatic longint unit_clamp(longint v);
    return v > UNIT_Q30 ? UNIT_Q30 : (v < -UNIT_Q30 ? -UNIT_Q30 : v);
  endfunction

  task automatic angle_trig(output longint c, output longint s);
    longint a, x, y, z, nx;
    longint unsigned mag, r;
    bit flip;
    a = angle_q16;
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (a > 180 * Q16_DEG) a -= 360 * Q16_DEG;
    if (a < -180 * Q16_DEG) a += 360 * Q16_DEG;
    if (a > 90 * Q16_DEG) begin
      a -= 180 * Q16_DEG;
      flip = 1'b1;
    end else if (a < -90 * Q16_DEG) begin
      a += 180 * Q16_DEG;
      flip = 1'b1;
    end
    mag = a < 0 ? longint'(-a) : longint'(a);
    r = (mag * RAD_PER_DEG_Q40 + (64'd1 << 25)) >> 26;
    z = a < 0 ? -longint'(r) : longint'(r);
    for (int i = 0; i < TRIG_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_q30[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_q30[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = unit_clamp(x);
    s = unit_clamp(y);
  endtask

  function automatic logic [31:0] scale_axis(longint f, longint p, longint piv, longint h,
                                              inout bit sat);
    longint ph;
    logic signed [127:0] ph_w;
    ph = piv * h;
    ph_w = ph;
    return round_clip(wide_mul(f, p * 65536 - ph) + (ph_w <<< 16), 32, sat);
  endfunction

  function automatic logic [31:0] rotate_axis(longint ka, longint da, longint kb, longint db,
                                               longint piv, longint h, inout bit sat);
    logic signed [127:0] base;
    base = piv * h;
    return round_clip(wide_mul(ka, da) + wide_mul(kb, db) + (base <<< 30), 46, sat);
  endfunction

  task automatic predict_vertex(input logic [2:0] mode, input logic [31:0] xi,
                                input logic [31:0] yi, input logic [31:0] zi,
                                input logic [31:0] wi, output vertex_res_t r);
    longint x, y, z, h, dx, dy, dz, c, s;
    logic signed [127:0] t;
    bit sat;
    x = longint'($signed(xi));
    y = longint'($signed(yi));
    z = longint'($signed(zi));
    h = longint'($signed(wi));
    dx = x * 65536 - pivot_pt[0] * h;
    dy = y * 65536 - pivot_pt[1] * h;
    dz = z * 65536 - pivot_pt[2] * h;
    sat = 1'b0;
    c = 0;
    s = 0;
    r.x = xi;
    r.y = yi;
    r.z = zi;
    r.w = wi;
    if (mode >= vpt_pkg::MODE_ROT_X && mode <= vpt_pkg::MODE_ROT_Z) angle_trig(c, s);
    case (mode)
      vpt_pkg::MODE_TRANSLATE: begin
        t = x * 65536 + scale_par[0] * h;
        r.x = round_clip(t, 16, sat);
        t = y * 65536 + scale_par[1] * h;
        r.y = round_clip(t, 16, sat);
        t = z * 65536 + scale_par[2] * h;
        r.z = round_clip(t, 16, sat);
      end
      vpt_pkg::MODE_SCALE: begin
        r.x = scale_axis(scale_par[0], x, pivot_pt[0], h, sat);
        r.y = scale_axis(scale_par[1], y, pivot_pt[1], h, sat);
        r.z = scale_axis(scale_par[2], z, pivot_pt[2], h, sat);
      end
      vpt_pkg::MODE_ROT_X: begin
        r.y = rotate_axis(c, dy, -s, dz, pivot_pt[1], h, sat);
        r.z = rotate_axis(s, dy, c, dz, pivot_pt[2], h, sat);
      end
      vpt_pkg::MODE_ROT_Y: begin
        r.x = rotate_axis(c, dx, s, dz, pivot_pt[0], h, sat);
        r.z = rotate_axis(-s, dx, c, dz, pivot_pt[2], h, sat);
      end
      vpt_pkg::MODE_ROT_Z: begin
        r.x = rotate_axis(c, dx, -s, dy, pivot_pt[0], h, sat);
        r.y = rotate_axis(s, dx, c, dy, pivot_pt[1], h, sat);
      end
      default: begin
      end
    endcase
    r.sat = sat;
  endtask

  task automatic write_reg(vpt_pkg::cfg_idx_e idx, logic [31:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      vpt_pkg::IDX_PARAM_X: scale_par[0] = longint'($signed(data));
      vpt_pkg::IDX_PARAM_Y: scale_par[1] = longint'($signed(data));
      vpt_pkg::IDX_PARAM_Z: scale_par[2] = longint'($signed(data));
      vpt_pkg::IDX_PIVOT_X: pivot_pt[0] = longint'($signed(data));
      vpt_pkg::IDX_PIVOT_Y: pivot_pt[1] = longint'($signed(data));
      vpt_pkg::IDX_PIVOT_Z: pivot_pt[2] = longint'($signed(data));
      default: angle_q16 = longint'($signed(data[25:0]));
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_all(logic [31:0] par, logic [31:0] piv, logic [31:0] ang);
    write_reg(vpt_pkg::IDX_PARAM_X, par);
    write_reg(vpt_pkg::IDX_PARAM_Y, par);
    write_reg(vpt_pkg::IDX_PARAM_Z, par);
    write_reg(vpt_pkg::IDX_PIVOT_X, piv);
    write_reg(vpt_pkg::IDX_PIVOT_Y, piv);
    write_reg(vpt_pkg::IDX_PIVOT_Z, piv);
    write_reg(vpt_pkg::IDX_ANGLE, ang);
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (expected_vertices.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic send_vertex(vertex_row_t row);
    vertex_res_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata = {row.w, row.z, row.y, row.x};
    s_axis_tuser = row.mode;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (row.typed) begin
      r.x = row.ex;
      r.y = row.ey;
      r.z = row.ez;
      r.w = row.w;
      r.sat = 1'b0;
    end else begin
      predict_vertex(row.mode, row.x, row.y, row.z, row.w, r);
    end
    expected_vertices.push_back(r);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'h00010000;
      default: return $urandom_range(0, 32'h0007FFFF) - 32'h00040000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 6))
          0: return 32'(360 * Q16_DEG);
          1: return 32'(-360 * Q16_DEG);
          2: return 32'(180 * Q16_DEG);
          3: return 32'(-180 * Q16_DEG);
          4: return 32'(90 * Q16_DEG);
          5: return 32'(-90 * Q16_DEG);
          default: return 32'd0;
        endcase
      end
      default: return $urandom_range(0, 2 * 23592960) - 32'd23592960;
    endcase
  endfunction

  function automatic vertex_row_t rand_row();
    vertex_row_t row;
    row.mode = 3'(($urandom_range(0, 9) < 9) ? $urandom_range(0, 4) : $urandom_range(5, 7));
    row.x = rand_coord();
    row.y = rand_coord();
    row.z = rand_coord();
    case ($urandom_range(0, 5))
      0: row.w = $urandom;
      1: row.w = $urandom_range(0, 32'h0003FFFF) - 32'h00020000;
      default: row.w = 32'h00010000;
    endcase
    row.typed = 1'b0;
    row.ex = '0;
    row.ey = '0;
    row.ez = '0;
    return row;
  endfunction

  always @(posedge clk_i) begin
    vertex_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_vertices.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        error_count++;
      end else begin
        e = expected_vertices.pop_front();
        if (m_axis_tdata[31:0] !== e.x) begin
          $error("x_out expected %h actual %h", e.x, m_axis_tdata[31:0]);
          error_count++;
        end
        if (m_axis_tdata[63:32] !== e.y) begin
          $error("y_out expected %h actual %h", e.y, m_axis_tdata[63:32]);
          error_count++;
        end
        if (m_axis_tdata[95:64] !== e.z) begin
          $error("z_out expected %h actual %h", e.z, m_axis_tdata[95:64]);
          error_count++;
        end
        if (m_axis_tdata[127:96] !== e.w) begin
          $error("w_out expected %h actual %h", e.w, m_axis_tdata[127:96]);
          error_count++;
        end
        if (m_axis_tuser[0] !== e.sat) begin
          $error("saturated expected %b actual %b", e.sat, m_axis_tuser[0]);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    vertex_row_t directed [$];
    vertex_row_t row;
    atan_q30 = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    for (int i = 0; i < 3; i++) begin
      scale_par[i] = 0;
      pivot_pt[i] = 0;
    end
    angle_q16 = 0;
    directed = '{
      '{vpt_pkg::MODE_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, 32'h0},
      '{vpt_pkg::MODE_TRANSLATE, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h7FFFFFFF, 1,
        32'h7FFFFFFF, 32'h80000000, 32'h1},
      '{vpt_pkg::MODE_TRANSLATE, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 1,
        32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF},
      '{vpt_pkg::MODE_SCALE, 32'h7FFFFFFF, 32'h80000000, 32'h12345678, 32'h00010000, 1,
        32'h0, 32'h0, 32'h0},
      '{vpt_pkg::MODE_ROT_X, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'h00010000,
        0, 0, 0, 0},
      '{vpt_pkg::MODE_ROT_Y, 32'h80000000, 32'h00020000, 32'h7FFFFFFF, 32'h80000000,
        0, 0, 0, 0},
      '{vpt_pkg::MODE_ROT_Z, 32'h00030000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
        0, 0, 0, 0},
      '{3'd5, 32'hDEADBEEF, 32'h80000000, 32'h7FFFFFFF, 32'h1, 1,
        32'hDEADBEEF, 32'h80000000, 32'h7FFFFFFF},
      '{3'd6, 32'h1, 32'h2, 32'h3, 32'h4, 1, 32'h1, 32'h2, 32'h3},
      '{3'd7, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0, 1, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF}
    };
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_vertex(directed[i]);
    drain();
    write_all(32'h7FFFFFFF, 32'h80000000, 32'(90 * Q16_DEG));
    foreach (directed[i]) begin
      row = directed[i];
      row.typed = 1'b0;
      send_vertex(row);
    end
    drain();
    write_all(32'h80000000, 32'h7FFFFFFF, 32'(-360 * Q16_DEG));
    for (int i = 4; i < 7; i++) begin
      row = directed[i];
      row.typed = 1'b0;
      send_vertex(row);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 70 : 0;
      recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 27 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        drain();
        write_reg(vpt_pkg::IDX_PARAM_X, rand_q16());
        write_reg(vpt_pkg::IDX_PARAM_Y, rand_q16());
        write_reg(vpt_pkg::IDX_PARAM_Z, rand_q16());
        write_reg(vpt_pkg::IDX_PIVOT_X, rand_q16());
        write_reg(vpt_pkg::IDX_PIVOT_Y, rand_q16());
        write_reg(vpt_pkg::IDX_PIVOT_Z, rand_q16());
        write_reg(vpt_pkg::IDX_ANGLE, rand_angle());
        for (int n = 0; n < 82; n++) send_vertex(rand_row());
      end
    end

    drain();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/vpt_pkg.sv
rtl/vpt_cordic.sv
rtl/vpt_lane.sv
rtl/vertex_pivot_transform.sv
rtl/vpt_checker.sv
tb/sv/tb_top.sv
